// ----- hw/rtl/rrs_pkg.sv -----
// shared constants, codes and item types for the row range set selector
`default_nettype none

package rrs_pkg;

  localparam int MAX_RANGES = 1024;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ROW_W      = 30;
  localparam int COUNT_W    = 11;

  localparam logic [ROW_W-1:0] OPEN_END = 30'd1000000000;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_START  = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [ROW_W-1:0] high;
    logic [ROW_W-1:0] low;
  } entry_t;

  typedef struct packed {
    mode_t            mode;
    logic [ROW_W-1:0] range_start;
    logic [ROW_W-1:0] range_end;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic               selected;
    logic [ROW_W-1:0]   row_number;
    logic               scan_done;
    logic [COUNT_W-1:0] range_count;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rrs_ram.sv -----
// simple dual-port ram, one write and one registered read per cycle
`default_nettype none

module rrs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 60
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rrs_seq.sv -----
// sequencer and datapath: range list search, merge, shift and row scan
`default_nettype none

module rrs_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  input  wire rrs_pkg::req_t req,
  output logic               req_ready,
  output logic               res_valid,
  output rrs_pkg::res_t      res,
  input  wire logic          res_ready
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_TICK, S_INS, S_BF, S_BC, S_AF, S_AC,
    S_DEC, S_UR, S_UW, S_MA, S_MB, S_DR, S_DW, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  logic [rrs_pkg::ROW_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [rrs_pkg::ROW_W-1:0] row_r, row_nxt, nb_r, nb_nxt;
  logic [rrs_pkg::ROW_W-1:0] nl_r, nl_nxt, nh_r, nh_nxt;
  logic [rrs_pkg::CNT_W-1:0] count_r, count_nxt, ptr_r, ptr_nxt;
  logic [rrs_pkg::CNT_W-1:0] bp1_r, bp1_nxt, a_r, a_nxt, r_r, r_nxt, k_r, k_nxt;
  logic                      inside_r, inside_nxt, fin_r, fin_nxt, sel_r, sel_nxt;
  rrs_pkg::status_t          status_r, status_nxt;

  logic                      mem_we;
  logic [rrs_pkg::IDX_W-1:0] mem_waddr, mem_raddr;
  rrs_pkg::entry_t           mem_wdata, mem_rdata;

  logic [rrs_pkg::CNT_W-1:0] ptr_inc, bp1_dec, a_dec, r_dec, r_inc, r_plus_k;
  logic [rrs_pkg::ROW_W:0]   hi_p1, rd_high_p1;
  logic [rrs_pkg::ROW_W-1:0] row_inc, rd_high_inc, nh_b;
  logic                      invalid;

  rrs_ram #(
    .DEPTH (rrs_pkg::MAX_RANGES),
    .WIDTH (2 * rrs_pkg::ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign ptr_inc     = ptr_r + rrs_pkg::CNT_W'(1);
  assign bp1_dec     = bp1_r - rrs_pkg::CNT_W'(1);
  assign a_dec       = a_r - rrs_pkg::CNT_W'(1);
  assign r_dec       = r_r - rrs_pkg::CNT_W'(1);
  assign r_inc       = r_r + rrs_pkg::CNT_W'(1);
  assign r_plus_k    = r_r + k_r;
  assign hi_p1       = {1'b0, hi_r} + (rrs_pkg::ROW_W + 1)'(1);
  assign rd_high_p1  = {1'b0, mem_rdata.high} + (rrs_pkg::ROW_W + 1)'(1);
  assign rd_high_inc = mem_rdata.high + rrs_pkg::ROW_W'(1);
  assign row_inc     = (row_r == '1) ? row_r : row_r + rrs_pkg::ROW_W'(1);
  assign nh_b        = (mem_rdata.high > nh_r) ? mem_rdata.high : nh_r;
  assign invalid     = (lo_r == '0) || (hi_r == '0) || (hi_r < lo_r) ||
                       (lo_r > rrs_pkg::OPEN_END) || (hi_r > rrs_pkg::OPEN_END);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res.status      = status_r;
    res.selected    = sel_r;
    res.row_number  = row_r;
    res.scan_done   = fin_r;
    res.range_count = rrs_pkg::COUNT_W'(count_r);
  end

  always_comb begin
    state_nxt  = state_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    row_nxt    = row_r;
    nb_nxt     = nb_r;
    nl_nxt     = nl_r;
    nh_nxt     = nh_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    bp1_nxt    = bp1_r;
    a_nxt      = a_r;
    r_nxt      = r_r;
    k_nxt      = k_r;
    inside_nxt = inside_r;
    fin_nxt    = fin_r;
    sel_nxt    = sel_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = r_r[rrs_pkg::IDX_W-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          lo_nxt     = req.range_start;
          hi_nxt     = req.range_end;
          sel_nxt    = 1'b0;
          status_nxt = rrs_pkg::ST_OK;
          unique case (req.mode)
            rrs_pkg::MODE_CLEAR: begin
              count_nxt  = '0;
              row_nxt    = '0;
              inside_nxt = 1'b0;
              nb_nxt     = '0;
              ptr_nxt    = '0;
              fin_nxt    = 1'b0;
              state_nxt  = S_RESP;
            end
            rrs_pkg::MODE_INSERT: begin
              state_nxt = S_INS;
            end
            rrs_pkg::MODE_START: begin
              mem_raddr = '0;
              state_nxt = S_START;
            end
            rrs_pkg::MODE_TICK: begin
              mem_raddr = inside_r ? ptr_inc[rrs_pkg::IDX_W-1:0]
                                   : ptr_r[rrs_pkg::IDX_W-1:0];
              state_nxt = S_TICK;
            end
          endcase
        end
      end

      S_START: begin
        row_nxt = '0;
        fin_nxt = 1'b0;
        ptr_nxt = '0;
        if (count_r == '0) begin
          inside_nxt = 1'b1;
          nb_nxt     = '0;
        end else begin
          inside_nxt = 1'b0;
          nb_nxt     = mem_rdata.low;
        end
        state_nxt = S_RESP;
      end

      S_TICK: begin
        row_nxt = row_inc;
        if (!fin_r) begin
          if (row_inc == nb_r) begin
            if (!inside_r) begin
              if (ptr_r >= count_r) begin
                fin_nxt = 1'b1;
              end else begin
                inside_nxt = 1'b1;
                nb_nxt     = rd_high_inc;
                sel_nxt    = 1'b1;
              end
            end else begin
              inside_nxt = 1'b0;
              ptr_nxt    = ptr_inc;
              if (ptr_inc >= count_r) begin
                fin_nxt = 1'b1;
              end else begin
                nb_nxt = mem_rdata.low;
              end
            end
          end else begin
            sel_nxt = inside_r;
          end
        end
        state_nxt = S_RESP;
      end

      S_INS: begin
        if (invalid) begin
          status_nxt = rrs_pkg::ST_INVALID;
          state_nxt  = S_RESP;
        end else begin
          bp1_nxt   = count_r;
          state_nxt = S_BF;
        end
      end

      // last range whose low lies at or below end + 1
      S_BF: begin
        if (bp1_r == '0) begin
          a_nxt     = '0;
          state_nxt = S_AF;
        end else begin
          mem_raddr = bp1_dec[rrs_pkg::IDX_W-1:0];
          state_nxt = S_BC;
        end
      end

      S_BC: begin
        if (hi_p1 >= {1'b0, mem_rdata.low}) begin
          a_nxt     = bp1_r;
          state_nxt = S_AF;
        end else begin
          bp1_nxt   = bp1_dec;
          state_nxt = S_BF;
        end
      end

      // first range whose high lies at or above start - 1
      S_AF: begin
        if (a_r == '0) begin
          state_nxt = S_DEC;
        end else begin
          mem_raddr = a_dec[rrs_pkg::IDX_W-1:0];
          state_nxt = S_AC;
        end
      end

      S_AC: begin
        if ({1'b0, lo_r} > rd_high_p1) begin
          state_nxt = S_DEC;
        end else begin
          a_nxt     = a_dec;
          state_nxt = S_AF;
        end
      end

      S_DEC: begin
        if (a_r == bp1_r) begin
          if (count_r >= rrs_pkg::CNT_W'(rrs_pkg::MAX_RANGES)) begin
            status_nxt = rrs_pkg::ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            r_nxt     = count_r;
            state_nxt = S_UR;
          end
        end else begin
          mem_raddr = a_r[rrs_pkg::IDX_W-1:0];
          state_nxt = S_MA;
        end
      end

      // shift up to open a slot
      S_UR: begin
        if (r_r == a_r) begin
          mem_we         = 1'b1;
          mem_waddr      = a_r[rrs_pkg::IDX_W-1:0];
          mem_wdata.low  = lo_r;
          mem_wdata.high = hi_r;
          count_nxt      = count_r + rrs_pkg::CNT_W'(1);
          state_nxt      = S_RESP;
        end else begin
          mem_raddr = r_dec[rrs_pkg::IDX_W-1:0];
          state_nxt = S_UW;
        end
      end

      S_UW: begin
        mem_we    = 1'b1;
        mem_waddr = r_r[rrs_pkg::IDX_W-1:0];
        mem_wdata = mem_rdata;
        r_nxt     = r_dec;
        state_nxt = S_UR;
      end

      // merge into slot a
      S_MA: begin
        nl_nxt    = (lo_r < mem_rdata.low) ? lo_r : mem_rdata.low;
        nh_nxt    = (hi_r > mem_rdata.high) ? hi_r : mem_rdata.high;
        mem_raddr = bp1_dec[rrs_pkg::IDX_W-1:0];
        state_nxt = S_MB;
      end

      S_MB: begin
        mem_we         = 1'b1;
        mem_waddr      = a_r[rrs_pkg::IDX_W-1:0];
        mem_wdata.low  = nl_r;
        mem_wdata.high = nh_b;
        k_nxt          = bp1_dec - a_r;
        count_nxt      = count_r - (bp1_dec - a_r);
        r_nxt          = a_r + rrs_pkg::CNT_W'(1);
        state_nxt      = (bp1_dec == a_r) ? S_RESP : S_DR;
      end

      // shift down to close merged slots
      S_DR: begin
        if (r_r >= count_r) begin
          state_nxt = S_RESP;
        end else begin
          mem_raddr = r_plus_k[rrs_pkg::IDX_W-1:0];
          state_nxt = S_DW;
        end
      end

      S_DW: begin
        mem_we    = 1'b1;
        mem_waddr = r_r[rrs_pkg::IDX_W-1:0];
        mem_wdata = mem_rdata;
        r_nxt     = r_inc;
        state_nxt = S_DR;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      row_r    <= '0;
      inside_r <= 1'b0;
      nb_r     <= '0;
      ptr_r    <= '0;
      fin_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      row_r    <= row_nxt;
      inside_r <= inside_nxt;
      nb_r     <= nb_nxt;
      ptr_r    <= ptr_nxt;
      fin_r    <= fin_nxt;
    end
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    nl_r     <= nl_nxt;
    nh_r     <= nh_nxt;
    bp1_r    <= bp1_nxt;
    a_r      <= a_nxt;
    r_r      <= r_nxt;
    k_r      <= k_nxt;
    sel_r    <= sel_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/row_range_set_selector.sv -----
// top level: stream ports, output register and range list sequencer
//
//  channel | direction | handshake         | payload
//  in_     | slave     | tvalid / tready   | tuser mode, tdata range bounds
//  out_    | master    | tvalid / tready   | tdata status, row and count fields
//
// clear goes straight to the result; scan start and row tick first read the range ram
// insert returns invalid status without touching the list, otherwise it searches the
// list, then shifts entries up or merges and shifts them down, reading one entry at a
// time through the single registered read port of the range ram
// one item at a time: in_tready is high only while the sequencer is idle
// a finished result waits in the output register; the next item is taken meanwhile
// synchronous active-low reset empties the list and clears the scan state
`default_nettype none

module row_range_set_selector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,  // mode
  input  wire logic [63:0] in_tdata,  // range_start, range_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata  // status, selected, row_number, scan_done, range_count
);

  rrs_pkg::req_t req;
  rrs_pkg::res_t res, out_data_r, out_data_nxt;
  logic          res_valid, res_ready;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    req.mode        = rrs_pkg::mode_t'(in_tuser);
    req.range_start = in_tdata[29:0];
    req.range_end   = in_tdata[59:30];
  end

  rrs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r.range_count, out_data_r.scan_done,
                       out_data_r.row_number, out_data_r.selected, out_data_r.status};

endmodule

`default_nettype wire

// ----- bench/tb_row_range_set_selector.sv -----
// testbench for the row range set selector: queued stimulus, in-bench predictor, result checks
`default_nettype none

module tb_row_range_set_selector;

  localparam int          ROW_MAX      = (1 << rrs_pkg::ROW_W) - 1;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          HOLD_AT      = 50;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          TAIL_CYCLES  = 100;
  localparam longint      CYCLE_LIMIT  = 20_000_000;

  typedef struct {
    rrs_pkg::mode_t            mode;
    logic [rrs_pkg::ROW_W-1:0] lo;
    logic [rrs_pkg::ROW_W-1:0] hi;
    int                        idle;
    int                        stall;
  } row_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = rrs_pkg::MODE_CLEAR;  // mode
  logic [63:0] in_tdata   = '0;          // range_start, range_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;                // status, selected, row_number, scan_done, range_count

  row_range_set_selector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  row_item_t     row_items[$];
  rrs_pkg::res_t pending_results[$];
  row_item_t     cur_item;
  row_item_t     next_item;
  rrs_pkg::res_t head_result;
  logic          in_fire     = 1'b0;
  int            stall_pct   = 0;
  int            cur_idle    = 0;
  int            cur_stall   = 0;
  int            n_accepted  = 0;
  int            hold_left   = 0;
  logic          hold_done   = 1'b0;
  int            errors      = 0;
  longint        cycle_cnt   = 0;

  // predictor state
  logic [rrs_pkg::ROW_W-1:0] span_low  [rrs_pkg::MAX_RANGES];
  logic [rrs_pkg::ROW_W-1:0] span_high [rrs_pkg::MAX_RANGES];
  int                        span_cnt  = 0;
  int                        span_ptr  = 0;
  logic [rrs_pkg::ROW_W-1:0] row_cnt   = '0;
  logic [rrs_pkg::ROW_W-1:0] next_edge = '0;
  logic                      in_span   = 1'b0;
  logic                      scan_fin  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rrs_pkg::status_t merge_span(logic [rrs_pkg::ROW_W-1:0] lo,
                                                  logic [rrs_pkg::ROW_W-1:0] hi);
    int     b, a, d, r;
    longint lo_l, hi_l;
    lo_l = lo;
    hi_l = hi;
    if (lo == 0 || hi == 0 || hi < lo || lo > rrs_pkg::OPEN_END || hi > rrs_pkg::OPEN_END)
      return rrs_pkg::ST_INVALID;
    // last range starting at or below hi+1, then first range ending at or above lo-1
    for (b = span_cnt - 1; b >= 0; b--)
      if (hi_l + 1 >= longint'(span_low[b])) break;
    for (a = b + 1; a > 0; a--)
      if (lo_l > longint'(span_high[a-1]) + 1) break;
    d = a - b;
    if (d == 1) begin
      if (span_cnt >= rrs_pkg::MAX_RANGES) return rrs_pkg::ST_FULL;
      for (r = span_cnt; r > a; r--) begin
        span_low[r]  = span_low[r-1];
        span_high[r] = span_high[r-1];
      end
      span_low[a]  = lo;
      span_high[a] = hi;
      span_cnt++;
    end else begin
      if (lo < span_low[a]) span_low[a] = lo;
      if (hi > span_high[a]) span_high[a] = hi;
      if (span_high[b] > span_high[a]) span_high[a] = span_high[b];
      for (r = a + 1; r < span_cnt + d; r++) begin
        span_low[r]  = span_low[r-d];
        span_high[r] = span_high[r-d];
      end
      span_cnt += d;
    end
    return rrs_pkg::ST_OK;
  endfunction

  function automatic logic next_row();
    if (row_cnt != rrs_pkg::ROW_W'(ROW_MAX)) row_cnt++;
    if (scan_fin) return 1'b0;
    if (row_cnt == next_edge) begin
      if (!in_span) begin
        if (span_ptr >= span_cnt) begin
          scan_fin = 1'b1;
          return 1'b0;
        end
        in_span   = 1'b1;
        next_edge = span_high[span_ptr] + 1'b1;
      end else begin
        in_span  = 1'b0;
        span_ptr = (span_ptr + 1) & 'h7FF;
        if (span_ptr >= span_cnt) begin
          scan_fin = 1'b1;
          return 1'b0;
        end
        next_edge = span_low[span_ptr];
      end
    end
    return in_span;
  endfunction

  function automatic rrs_pkg::res_t selector_result(row_item_t it);
    rrs_pkg::res_t r;
    r = '0;
    case (it.mode)
      rrs_pkg::MODE_CLEAR: begin
        span_cnt  = 0;
        row_cnt   = '0;
        in_span   = 1'b0;
        next_edge = '0;
        span_ptr  = 0;
        scan_fin  = 1'b0;
      end
      rrs_pkg::MODE_INSERT: r.status = merge_span(it.lo, it.hi);
      rrs_pkg::MODE_START: begin
        row_cnt  = '0;
        scan_fin = 1'b0;
        span_ptr = 0;
        // an empty list selects every row
        in_span   = (span_cnt == 0);
        next_edge = (span_cnt == 0) ? '0 : span_low[0];
      end
      default: r.selected = next_row();
    endcase
    r.row_number  = row_cnt;
    r.scan_done   = scan_fin;
    r.range_count = rrs_pkg::COUNT_W'(span_cnt);
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic push_item(rrs_pkg::mode_t m, int unsigned lo, int unsigned hi);
    row_item_t it;
    it.mode  = m;
    it.lo    = rrs_pkg::ROW_W'(lo);
    it.hi    = rrs_pkg::ROW_W'(hi);
    it.idle  = cur_idle;
    it.stall = cur_stall;
    row_items.push_back(it);
  endtask

  task automatic push_tick();
    push_item(rrs_pkg::MODE_TICK, $urandom_range(0, ROW_MAX), $urandom_range(0, ROW_MAX));
  endtask

  task automatic push_random_insert();
    int unsigned lo, hi;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      lo = $urandom_range(1, 60);
      hi = lo + $urandom_range(0, 8);
    end else if (pick < 78) begin
      lo = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 40)
                                       : $urandom_range(1, rrs_pkg::OPEN_END);
      hi = rrs_pkg::OPEN_END;
    end else if (pick < 90) begin
      lo = $urandom_range(0, ROW_MAX);
      hi = $urandom_range(0, ROW_MAX);
    end else begin
      case ($urandom_range(0, 2))
        0: begin lo = 0; hi = $urandom_range(0, 60); end
        1: begin lo = $urandom_range(1, 60); hi = 0; end
        default: begin lo = $urandom_range(2, 60); hi = $urandom_range(1, lo - 1); end
      endcase
    end
    push_item(rrs_pkg::MODE_INSERT, lo, hi);
  endtask

  // handshakes sampled at the rising edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      pending_results.push_back(selector_result(cur_item));
      n_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: %h", out_tdata);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", head_result.status, out_tdata[1:0]);
        check_field("selected", head_result.selected, out_tdata[2]);
        check_field("row_number", head_result.row_number, out_tdata[32:3]);
        check_field("scan_done", head_result.scan_done, out_tdata[33]);
        check_field("range_count", head_result.range_count, out_tdata[44:34]);
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (row_items.size() != 0 && $urandom_range(0, 99) >= row_items[0].idle) begin
        next_item = row_items.pop_front();
        cur_item  <= next_item;
        in_tuser  <= next_item.mode;
        in_tdata  <= {4'b0000, next_item.hi, next_item.lo};
        stall_pct <= next_item.stall;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int idle_tab [4];
    int stall_tab[4];
    int base, phase, n_ins, n_tk, k;
    idle_tab  = '{0, 54, 0, 34};
    stall_tab = '{0, 0, 54, 34};

    // ticks before any scan, then a scan over an empty list
    push_tick();
    push_tick();
    push_item(rrs_pkg::MODE_START, 0, 0);
    push_tick();
    push_tick();
    // invalid ranges
    push_item(rrs_pkg::MODE_INSERT, 0, 5);
    push_item(rrs_pkg::MODE_INSERT, 5, 0);
    push_item(rrs_pkg::MODE_INSERT, 9, 8);
    push_item(rrs_pkg::MODE_INSERT, rrs_pkg::OPEN_END + 1, rrs_pkg::OPEN_END + 1);
    push_item(rrs_pkg::MODE_INSERT, 1, ROW_MAX);
    // extremes, then touching and bridging merges
    push_item(rrs_pkg::MODE_INSERT, 1, 1);
    push_item(rrs_pkg::MODE_INSERT, rrs_pkg::OPEN_END, rrs_pkg::OPEN_END);
    push_item(rrs_pkg::MODE_INSERT, 3, 4);
    push_item(rrs_pkg::MODE_INSERT, 2, 2);
    push_item(rrs_pkg::MODE_INSERT, 6, 7);
    push_item(rrs_pkg::MODE_INSERT, 5, 5);
    push_item(rrs_pkg::MODE_START, 0, 0);
    push_tick();
    push_tick();
    push_tick();
    // insert while scanning
    push_item(rrs_pkg::MODE_INSERT, 9, 9);
    // clear, then a scan that runs past the last range
    push_item(rrs_pkg::MODE_CLEAR, ROW_MAX, ROW_MAX);
    push_item(rrs_pkg::MODE_INSERT, 2, 3);
    push_item(rrs_pkg::MODE_START, 0, 0);
    repeat (5) push_tick();

    base = row_items.size();
    while (row_items.size() - base < RANDOM_ITEMS) begin
      phase     = (row_items.size() - base) * 4 / RANDOM_ITEMS;
      cur_idle  = idle_tab[phase];
      cur_stall = stall_tab[phase];
      if ($urandom_range(0, 9) < 8) push_item(rrs_pkg::MODE_CLEAR, 0, 0);
      n_ins = $urandom_range(0, 6);
      repeat (n_ins) push_random_insert();
      if ($urandom_range(0, 9) < 8) push_item(rrs_pkg::MODE_START, 0, 0);
      n_tk = $urandom_range(0, 70);
      for (k = 0; k < n_tk; k++) begin
        if ($urandom_range(0, 29) == 0) push_random_insert();
        else if ($urandom_range(0, 59) == 0) push_item(rrs_pkg::MODE_START, 0, 0);
        else push_tick();
      end
    end

    // fill the list to its limit in ascending order
    cur_idle  = 0;
    cur_stall = 0;
    push_item(rrs_pkg::MODE_CLEAR, 0, 0);
    for (k = 0; k < rrs_pkg::MAX_RANGES; k++)
      push_item(rrs_pkg::MODE_INSERT, 4 * k + 1, 4 * k + 2);
    push_item(rrs_pkg::MODE_INSERT, 5000, 5000);
    push_item(rrs_pkg::MODE_INSERT, 0, 0);
    push_item(rrs_pkg::MODE_INSERT, 4 * rrs_pkg::MAX_RANGES - 1, 4 * rrs_pkg::MAX_RANGES - 1);
    push_item(rrs_pkg::MODE_INSERT, 3, 4);
    push_item(rrs_pkg::MODE_INSERT, 5000, 5000);
    push_item(rrs_pkg::MODE_INSERT, 6000, 6000);
    push_item(rrs_pkg::MODE_START, 0, 0);
    repeat (12) push_tick();
    push_item(rrs_pkg::MODE_CLEAR, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (row_items.size() != 0 || in_tvalid || pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
